/* sv/tds_pkg.sv */
// package for the toroidal diffusion step: widths, codes and size constants
package tds_pkg;
  localparam int MaxColumns = 64;
  localparam int MaxRows = 64;
  localparam int AmountW = 32;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_STEP  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_COLUMNS = 2'd0,
    REG_ROWS    = 2'd1,
    REG_DIFF    = 2'd2,
    REG_DECAY   = 2'd3
  } reg_idx_t;
endpackage

/* sv/tds_if.sv */
// request, result and configuration channel interfaces
interface tds_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [5:0]  cell_x;
  logic [5:0]  cell_y;
  logic [31:0] amount_in;
  modport source (output valid, operation, cell_x, cell_y, amount_in, input ready);
  modport sink (input valid, operation, cell_x, cell_y, amount_in, output ready);
endinterface

interface tds_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] amount_out;
  logic [1:0]  done_kind;
  logic        saturated;
  modport source (output valid, amount_out, done_kind, saturated, input ready);
  modport sink (input valid, amount_out, done_kind, saturated, output ready);
endinterface

interface tds_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/toroidal_diffusion_step.sv */
// Toroidal 3x3 diffusion step with decay over a grid of Q16.16 amounts held in
// one synchronous memory, with a second memory as the snapshot of the old grid.
// A step first copies the whole store of N entries into the snapshot, one entry
// a cycle (N is MAX_COLUMNS*MAX_ROWS, each side rounded up to a power of two).
// It then updates each cell in use by reading its nine window cells from the
// snapshot, one per cycle through the single read port. Next the states S_MUL,
// S_SUB, S_DEC and S_STORE do the gain and loss products, the subtraction,
// the decay product and the saturating write-back. One request is handled at a
// time. A new request is taken only once the previous result has left the
// output register or is leaving it in that cycle.
module toroidal_diffusion_step #(
  parameter int MAX_COLUMNS = tds_pkg::MaxColumns,
  parameter int MAX_ROWS = tds_pkg::MaxRows
) (
  input logic clk,
  input logic rst,
  tds_cfg_if.sink cfg,
  tds_req_if.sink req,
  tds_rsp_if.source rsp
);
  localparam int XW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int YW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int AW = XW + YW;
  localparam int Depth = 1 << AW;
  localparam int CW = $clog2(MAX_COLUMNS + 1);
  localparam int RW = $clog2(MAX_ROWS + 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_ACC   = 9'b000000010,
    S_COPY  = 9'b000000100,
    S_WIN   = 9'b000001000,
    S_MUL   = 9'b000010000,
    S_SUB   = 9'b000100000,
    S_DEC   = 9'b001000000,
    S_STORE = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state;
  logic [31:0] grid [Depth];
  logic [31:0] scratch [Depth];
  logic [31:0] grid_q, scratch_q;

  logic [6:0]  grid_columns, grid_rows;
  logic [15:0] diffusion_fraction;
  logic [16:0] decay_fraction;

  logic [1:0]  op;
  logic [5:0]  cx, cy;
  logic [31:0] amt;
  logic        rd_pend;
  logic [AW:0] copy_cnt;
  logic        copy_vld;
  logic [AW-1:0] copy_addr;
  logic [XW-1:0] px, nx;
  logic [YW-1:0] py, ny;
  logic [1:0]  di, dj;
  logic [3:0]  win_cnt;
  logic        win_vld;
  logic [35:0] sum;
  logic [31:0] a;
  logic [52:0] gain_p;
  logic [52:0] loss_p;
  logic [36:0] v;
  logic [53:0] r_p;
  logic        sat;
  logic        out_valid;
  logic [31:0] out_amount;
  logic [1:0]  out_kind;
  logic        out_sat;

  logic [CW-1:0] cols;
  logic [RW-1:0] rows;
  logic [16:0] keep;
  logic        cell_inside;
  logic [AW-1:0] cell_addr, win_addr, pos_addr;
  logic [XW:0] wx;
  logic [YW:0] wy;
  logic [37:0] v_wide;
  logic [53:0] r_next;

  always_comb begin
    if (grid_columns == 7'd0) cols = CW'(1);
    else if (32'(grid_columns) > MAX_COLUMNS) cols = CW'(MAX_COLUMNS);
    else cols = CW'(grid_columns);
    if (grid_rows == 7'd0) rows = RW'(1);
    else if (32'(grid_rows) > MAX_ROWS) rows = RW'(MAX_ROWS);
    else rows = RW'(grid_rows);
    keep = (decay_fraction > 17'd65536) ? 17'd0 : 17'd65536 - decay_fraction;
    cell_inside = (32'(cx) < MAX_COLUMNS) && (32'(cy) < MAX_ROWS);
    cell_addr = {YW'(cy), XW'(cx)};
    if (di == 2'd0) wx = (px == '0) ? (XW+1)'(cols) - 1'b1 : {1'b0, px} - 1'b1;
    else if (di == 2'd1) wx = {1'b0, px};
    else wx = ((XW+1)'(px) + 1'b1 == (XW+1)'(cols)) ? '0 : {1'b0, px} + 1'b1;
    if (dj == 2'd0) wy = (py == '0) ? (YW+1)'(rows) - 1'b1 : {1'b0, py} - 1'b1;
    else if (dj == 2'd1) wy = {1'b0, py};
    else wy = ((YW+1)'(py) + 1'b1 == (YW+1)'(rows)) ? '0 : {1'b0, py} + 1'b1;
    win_addr = {wy[YW-1:0], wx[XW-1:0]};
    pos_addr = {py, px};
    v_wide = {6'd0, a} + {2'd0, gain_p[51:16]};
    r_next = v * keep;
  end

  assign cfg.ready = 1'b1;
  assign req.ready = (state == S_IDLE) && (!out_valid || rsp.ready);
  assign rsp.valid = out_valid;
  assign rsp.amount_out = out_amount;
  assign rsp.done_kind = out_kind;
  assign rsp.saturated = out_sat;
  assign copy_addr = copy_cnt[AW-1:0];

  always_ff @(posedge clk) begin
    grid_q <= grid[(state == S_COPY) ? copy_addr : cell_addr];
    scratch_q <= scratch[win_addr];
    if (state == S_ACC && op == tds_pkg::OP_WRITE && cell_inside) grid[cell_addr] <= amt;
    if (copy_vld) scratch[copy_cnt[AW-1:0] - 1'b1] <= grid_q;
    if (state == S_STORE)
      grid[pos_addr] <= (r_p[53:16] > 38'hFFFFFFFF) ? 32'hFFFFFFFF : r_p[47:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns <= 7'd64;
      grid_rows <= 7'd64;
      diffusion_fraction <= '0;
      decay_fraction <= '0;
    end else if (cfg.valid) begin
      unique case (tds_pkg::reg_idx_t'(cfg.index[1:0]))
        tds_pkg::REG_COLUMNS: if (cfg.index[7:2] == '0) grid_columns <= cfg.data[6:0];
        tds_pkg::REG_ROWS: if (cfg.index[7:2] == '0) grid_rows <= cfg.data[6:0];
        tds_pkg::REG_DIFF: if (cfg.index[7:2] == '0) diffusion_fraction <= cfg.data[15:0];
        tds_pkg::REG_DECAY: if (cfg.index[7:2] == '0) decay_fraction <= cfg.data[16:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      rd_pend <= 1'b0;
      copy_vld <= 1'b0;
      win_vld <= 1'b0;
    end else begin
      if (rsp.ready && state != S_DONE) out_valid <= 1'b0;
      copy_vld <= (state == S_COPY) && (copy_cnt != (AW+1)'(Depth));
      win_vld <= (state == S_WIN) && (win_cnt != 4'd9);
      unique case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            op <= req.operation;
            cx <= req.cell_x;
            cy <= req.cell_y;
            amt <= req.amount_in;
            rd_pend <= 1'b0;
            state <= S_ACC;
          end
        end
        S_ACC: begin
          if (op == tds_pkg::OP_STEP) begin
            copy_cnt <= '0;
            sat <= 1'b0;
            state <= S_COPY;
          end else if (op == tds_pkg::OP_READ && !rd_pend) begin
            rd_pend <= 1'b1;
          end else begin
            out_amount <= (op == tds_pkg::OP_READ && cell_inside) ? grid_q : 32'd0;
            state <= S_DONE;
          end
        end
        S_COPY: begin
          if (copy_cnt == (AW+1)'(Depth)) begin
            px <= '0;
            py <= '0;
            di <= '0;
            dj <= '0;
            win_cnt <= '0;
            sum <= '0;
            state <= S_WIN;
          end else begin
            copy_cnt <= copy_cnt + 1'b1;
          end
        end
        S_WIN: begin
          if (win_vld) begin
            sum <= sum + 36'(scratch_q);
            if (win_cnt == 4'd5) a <= scratch_q;
          end
          if (win_cnt == 4'd9) begin
            if (!win_vld) state <= S_MUL;
          end else begin
            win_cnt <= win_cnt + 1'b1;
            if (di == 2'd2) begin
              di <= '0;
              dj <= dj + 1'b1;
            end else begin
              di <= di + 1'b1;
            end
          end
        end
        S_MUL: begin
          gain_p <= 53'(sum) * 53'(diffusion_fraction);
          loss_p <= 53'(a) * 53'(diffusion_fraction) * 53'd9;
          state <= S_SUB;
        end
        S_SUB: begin
          if (v_wide < {2'd0, loss_p[51:16]}) begin
            v <= '0;
            sat <= 1'b1;
          end else begin
            v <= 37'(v_wide - {2'd0, loss_p[51:16]});
          end
          state <= S_DEC;
        end
        S_DEC: begin
          r_p <= r_next;
          state <= S_STORE;
        end
        S_STORE: begin
          if (r_p[53:16] > 38'hFFFFFFFF) sat <= 1'b1;
          win_cnt <= '0;
          di <= '0;
          dj <= '0;
          sum <= '0;
          if ((XW+1)'(px) + 1'b1 == (XW+1)'(cols)) begin
            px <= '0;
            if ((YW+1)'(py) + 1'b1 == (YW+1)'(rows)) begin
              out_amount <= '0;
              state <= S_DONE;
            end else begin
              py <= py + 1'b1;
              state <= S_WIN;
            end
          end else begin
            px <= px + 1'b1;
            state <= S_WIN;
          end
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_kind <= op;
            out_sat <= (op == tds_pkg::OP_STEP) ? sat : 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_req_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !req.ready) else $error("request taken while busy");
  a_sat_only_step: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.saturated) |-> (rsp.done_kind == tds_pkg::OP_STEP))
    else $error("saturation flagged outside a step");
  a_zero_write: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.done_kind != tds_pkg::OP_READ) |-> (rsp.amount_out == '0))
    else $error("non-read result carries an amount");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |=> rsp.valid) else $error("result dropped");
`endif
endmodule
